@@ rtl/lfal_pkg.sv @@
// Shared types and constants for the per-axis feedrate and acceleration limiter.
package lfal_pkg;

    localparam int DataW  = 32;           // width of every field and register
    localparam int ProdW  = 2 * DataW;    // exact product of two fields
    localparam int ValW   = DataW + 1;    // clamped axis speed or accel
    localparam int ExcW   = DataW + 3;    // signed excess over a limit
    localparam int Axes   = 4;            // X, Y, Z, extruder
    localparam int AddrW  = 5;            // eight 32-bit registers

    // register index, taken from paddr[4:2]
    typedef enum logic [2:0] {
        REG_MAX_SPEED_X = 3'd0,
        REG_MAX_SPEED_Y = 3'd1,
        REG_MAX_SPEED_Z = 3'd2,
        REG_MAX_SPEED_E = 3'd3,
        REG_MAX_ACCEL_X = 3'd4,
        REG_MAX_ACCEL_Y = 3'd5,
        REG_MAX_ACCEL_Z = 3'd6,
        REG_MAX_ACCEL_E = 3'd7
    } t_reg;

    typedef enum logic [2:0] {
        PICK_NONE = 3'd0,
        PICK_X    = 3'd1,
        PICK_Y    = 3'd2,
        PICK_Z    = 3'd3,
        PICK_E    = 3'd4
    } t_pick;

    // axis magnitudes plus requested feed and accel
    typedef struct packed {
        logic [DataW-1:0] dx;
        logic [DataW-1:0] dy;
        logic [DataW-1:0] dz;
        logic [DataW-1:0] de;
        logic [DataW-1:0] feed;
        logic [DataW-1:0] accel;
    } t_move;

    typedef struct packed {
        t_move            mv;
        logic [DataW-1:0] len;
    } t_move_len;

    // final selection for one quantity
    typedef struct packed {
        logic             keep;     // nothing exceeded: pass request through
        logic             use_lim;  // extruder pick on a zero-length move
        logic [DataW-1:0] lim;
    } t_sel;

    typedef struct packed {
        t_sel             feed_sel;
        t_sel             accel_sel;
        logic [DataW-1:0] feed;
        logic [DataW-1:0] accel;
    } t_fin;

endpackage

@@ rtl/line_feed_accel_axis_limiter_core.sv @@
// Top level of the per-axis feedrate and acceleration limiter pipeline.
//
//  channel   direction  handshake                    payload
//  move in   input      i_in_valid / o_in_ready      i_delta_x/y/z, i_extrude_dist,
//                                                    i_req_feed, i_req_accel
//  result    output     o_out_valid / i_out_ready    o_out_feed, o_out_accel
//  config    input      psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// One item per cycle unless the output stalls. Stages: 3 front stages, a 32-stage square root,
// one multiply stage, a 34-stage divider for the axis speeds and accels, 4 compare
// and select stages, a 33-stage divider for the rescale, and the output register.
// The whole pipeline advances together whenever the output register is empty or
// taken, so a stall freezes every stage in place. Reset clears the valid bits and
// the limit registers to zero.
module line_feed_accel_axis_limiter_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [lfal_pkg::DataW-1:0] i_delta_x,
    input  logic signed [lfal_pkg::DataW-1:0] i_delta_y,
    input  logic signed [lfal_pkg::DataW-1:0] i_delta_z,
    input  logic signed [lfal_pkg::DataW-1:0] i_extrude_dist,
    input  logic [lfal_pkg::DataW-1:0]    i_req_feed,
    input  logic [lfal_pkg::DataW-1:0]    i_req_accel,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [lfal_pkg::DataW-1:0]    o_out_feed,
    output logic [lfal_pkg::DataW-1:0]    o_out_accel,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lfal_pkg::AddrW-1:0]    paddr,
    input  logic [lfal_pkg::DataW-1:0]    pwdata,
    output logic [lfal_pkg::DataW-1:0]    prdata,
    output logic                          pready
);
    import lfal_pkg::*;

    localparam int MlW  = $bits(t_move_len);
    localparam int MvW  = $bits(t_move);
    localparam int FinW = $bits(t_fin);
    localparam int Lanes2 = 2 * Axes;

    function automatic logic [DataW-1:0] mag32(input logic [DataW-1:0] v);
        return v[DataW-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic t_pick pick4(input logic signed [ExcW-1:0] x,
                                    input logic signed [ExcW-1:0] y,
                                    input logic signed [ExcW-1:0] z,
                                    input logic signed [ExcW-1:0] e);
        t_pick p;
        if (!(x > 0 || y > 0 || z > 0 || e > 0)) p = PICK_NONE;
        else if (x > y) begin
            if (x > z) p = (x > e) ? PICK_X : PICK_E;
            else       p = (z > e) ? PICK_Z : PICK_E;
        end else begin
            if (y > z) p = (y > e) ? PICK_Y : PICK_E;
            else       p = (z > e) ? PICK_Z : PICK_E;
        end
        return p;
    endfunction

    function automatic logic [DataW-1:0] sel4(input t_pick p,
                                              input logic [DataW-1:0] vx,
                                              input logic [DataW-1:0] vy,
                                              input logic [DataW-1:0] vz,
                                              input logic [DataW-1:0] ve);
        logic [DataW-1:0] r;
        unique case (p)
            PICK_X:  r = vx;
            PICK_Y:  r = vy;
            PICK_Z:  r = vz;
            PICK_E:  r = ve;
            default: r = vx;
        endcase
        return r;
    endfunction

    // ---------------- configuration ----------------
    logic [DataW-1:0] r_max_speed [Axes];
    logic [DataW-1:0] r_max_accel [Axes];
    logic             cfg_wr;
    t_reg             cfg_reg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_reg = t_reg'(paddr[AddrW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < Axes; i++) begin
                r_max_speed[i] <= '0;
                r_max_accel[i] <= '0;
            end
        end else if (cfg_wr) begin
            unique case (cfg_reg)
                REG_MAX_SPEED_X: r_max_speed[0] <= pwdata;
                REG_MAX_SPEED_Y: r_max_speed[1] <= pwdata;
                REG_MAX_SPEED_Z: r_max_speed[2] <= pwdata;
                REG_MAX_SPEED_E: r_max_speed[3] <= pwdata;
                REG_MAX_ACCEL_X: r_max_accel[0] <= pwdata;
                REG_MAX_ACCEL_Y: r_max_accel[1] <= pwdata;
                REG_MAX_ACCEL_Z: r_max_accel[2] <= pwdata;
                REG_MAX_ACCEL_E: r_max_accel[3] <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_reg)
            REG_MAX_SPEED_X: prdata = r_max_speed[0];
            REG_MAX_SPEED_Y: prdata = r_max_speed[1];
            REG_MAX_SPEED_Z: prdata = r_max_speed[2];
            REG_MAX_SPEED_E: prdata = r_max_speed[3];
            REG_MAX_ACCEL_X: prdata = r_max_accel[0];
            REG_MAX_ACCEL_Y: prdata = r_max_accel[1];
            REG_MAX_ACCEL_Z: prdata = r_max_accel[2];
            REG_MAX_ACCEL_E: prdata = r_max_accel[3];
        endcase
    end

    // ---------------- pipeline control ----------------
    logic en;
    logic r_out_vld;
    assign en         = !r_out_vld || i_out_ready;
    assign o_in_ready = en;

    // S0: magnitudes
    logic  r_s0_vld;
    t_move r_s0_mv;
    // S1: squares
    logic             r_s1_vld;
    t_move            r_s1_mv;
    logic [ProdW-1:0] r_s1_sq [3];
    // S2: sum of squares
    logic             r_s2_vld;
    t_move            r_s2_mv;
    logic [ProdW-1:0] r_s2_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else if (en) begin
            r_s0_vld <= i_in_valid;
            r_s1_vld <= r_s0_vld;
            r_s2_vld <= r_s1_vld;
        end
        if (en) begin
            r_s0_mv.dx    <= mag32(i_delta_x);
            r_s0_mv.dy    <= mag32(i_delta_y);
            r_s0_mv.dz    <= mag32(i_delta_z);
            r_s0_mv.de    <= mag32(i_extrude_dist);
            r_s0_mv.feed  <= i_req_feed;
            r_s0_mv.accel <= i_req_accel;
            r_s1_mv       <= r_s0_mv;
            r_s1_sq[0]    <= ProdW'(r_s0_mv.dx) * ProdW'(r_s0_mv.dx);
            r_s1_sq[1]    <= ProdW'(r_s0_mv.dy) * ProdW'(r_s0_mv.dy);
            r_s1_sq[2]    <= ProdW'(r_s0_mv.dz) * ProdW'(r_s0_mv.dz);
            r_s2_mv       <= r_s1_mv;
            r_s2_sum      <= r_s1_sq[0] + r_s1_sq[1] + r_s1_sq[2];
        end
    end

    // ---------------- length ----------------
    logic             sq_vld;
    logic [DataW-1:0] sq_len;
    logic [MvW-1:0]   sq_side;

    lfal_sqrt_pipe #(
        .RootW (DataW),
        .SideW (MvW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s2_vld),
        .i_rad   (r_s2_sum),
        .i_side  (r_s2_mv),
        .o_valid (sq_vld),
        .o_root  (sq_len),
        .o_side  (sq_side)
    );

    // S3: products for speeds (lanes 0..3) and accels (lanes 4..7)
    logic                        r_s3_vld;
    t_move_len                   r_s3_ml;
    logic [Lanes2-1:0][ProdW-1:0] r_s3_prod;
    logic [Lanes2-1:0][DataW-1:0] div_a_den;
    t_move                       sq_mv;

    assign sq_mv = t_move'(sq_side);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (en) begin
            r_s3_vld <= sq_vld;
        end
        if (en) begin
            r_s3_ml.mv   <= sq_mv;
            r_s3_ml.len  <= sq_len;
            r_s3_prod[0] <= ProdW'(sq_mv.dx) * ProdW'(sq_mv.feed);
            r_s3_prod[1] <= ProdW'(sq_mv.dy) * ProdW'(sq_mv.feed);
            r_s3_prod[2] <= ProdW'(sq_mv.dz) * ProdW'(sq_mv.feed);
            r_s3_prod[3] <= ProdW'(sq_mv.de) * ProdW'(sq_mv.feed);
            r_s3_prod[4] <= ProdW'(sq_mv.dx) * ProdW'(sq_mv.accel);
            r_s3_prod[5] <= ProdW'(sq_mv.dy) * ProdW'(sq_mv.accel);
            r_s3_prod[6] <= ProdW'(sq_mv.dz) * ProdW'(sq_mv.accel);
            r_s3_prod[7] <= ProdW'(sq_mv.de) * ProdW'(sq_mv.accel);
        end
    end

    always_comb begin
        for (int l = 0; l < Lanes2; l++) begin
            div_a_den[l] = r_s3_ml.len;
        end
    end

    logic                         da_vld;
    logic [Lanes2-1:0][ValW-1:0]  da_quo;
    logic [Lanes2-1:0]            da_ovf;
    logic [MlW-1:0]               da_side;

    lfal_div_pipe #(
        .Lanes (Lanes2),
        .NumW  (ProdW),
        .DenW  (DataW),
        .QuoW  (ValW),
        .SideW (MlW)
    ) u_div_rate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s3_vld),
        .i_num   (r_s3_prod),
        .i_den   (div_a_den),
        .i_side  (r_s3_ml),
        .o_valid (da_vld),
        .o_quo   (da_quo),
        .o_ovf   (da_ovf),
        .o_side  (da_side)
    );

    // S4: axis values with zero-length and zero-feed cases; overflow clamps,
    // which keeps every comparison against a 32-bit limit intact
    logic            r_s4_vld;
    t_move_len       r_s4_ml;
    logic [ValW-1:0] r_s4_val [Lanes2];
    logic [ValW-1:0] n_s4_val [Lanes2];
    t_move_len       da_ml;
    logic            da_len0;
    logic            da_feed0;

    assign da_ml    = t_move_len'(da_side);
    assign da_len0  = da_ml.len == '0;
    assign da_feed0 = da_ml.mv.feed == '0;

    always_comb begin
        logic [ValW-1:0] q;
        for (int l = 0; l < Lanes2; l++) begin
            q = da_ovf[l] ? {ValW{1'b1}} : da_quo[l];
            if (l == Axes - 1)
                n_s4_val[l] = da_len0 ? ValW'(da_ml.mv.feed) : q;
            else if (l == Lanes2 - 1)
                n_s4_val[l] = da_len0 ? ValW'(da_ml.mv.accel) : q;
            else if (l < Axes)
                n_s4_val[l] = da_len0 ? '0 : q;
            else
                n_s4_val[l] = (da_len0 || da_feed0) ? '0 : q;
        end
    end

    // S5: signed excess over each limit
    logic                   r_s5_vld;
    t_move_len              r_s5_ml;
    logic signed [ExcW-1:0] r_s5_exc [Lanes2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
        end else if (en) begin
            r_s4_vld <= da_vld;
            r_s5_vld <= r_s4_vld;
        end
        if (en) begin
            r_s4_ml <= da_ml;
            r_s5_ml <= r_s4_ml;
            for (int l = 0; l < Lanes2; l++) begin
                r_s4_val[l] <= n_s4_val[l];
            end
            for (int l = 0; l < Axes; l++) begin
                r_s5_exc[l] <= $signed(ExcW'(r_s4_val[l])) - $signed(ExcW'(r_max_speed[l]));
                r_s5_exc[l+Axes] <= $signed(ExcW'(r_s4_val[l+Axes]))
                                  - $signed(ExcW'(r_max_accel[l]));
            end
        end
    end

    // S6: pick the axis and its limit and divisor
    t_pick            f_pick;
    t_pick            a_pick;
    logic             s5_len0;
    t_sel             n_fsel;
    t_sel             n_asel;
    logic             r_s6_vld;
    t_sel             r_s6_fsel;
    t_sel             r_s6_asel;
    logic [DataW-1:0] r_s6_fden;
    logic [DataW-1:0] r_s6_aden;
    logic [DataW-1:0] r_s6_len;
    logic [DataW-1:0] r_s6_feed;
    logic [DataW-1:0] r_s6_accel;

    assign f_pick  = pick4(r_s5_exc[0], r_s5_exc[1], r_s5_exc[2], r_s5_exc[3]);
    assign a_pick  = pick4(r_s5_exc[4], r_s5_exc[5], r_s5_exc[6], r_s5_exc[7]);
    assign s5_len0 = r_s5_ml.len == '0;

    always_comb begin
        n_fsel.keep    = f_pick == PICK_NONE;
        n_fsel.use_lim = (f_pick == PICK_E) && s5_len0;
        n_fsel.lim     = sel4(f_pick, r_max_speed[0], r_max_speed[1],
                              r_max_speed[2], r_max_speed[3]);
        n_asel.keep    = a_pick == PICK_NONE;
        n_asel.use_lim = (a_pick == PICK_E) && s5_len0;
        n_asel.lim     = sel4(a_pick, r_max_accel[0], r_max_accel[1],
                              r_max_accel[2], r_max_accel[3]);
    end

    // S7: limit * length
    logic                        r_s7_vld;
    logic [1:0][ProdW-1:0]       r_s7_prod;
    logic [1:0][DataW-1:0]       r_s7_den;
    t_fin                        r_s7_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_vld <= 1'b0;
            r_s7_vld <= 1'b0;
        end else if (en) begin
            r_s6_vld <= r_s5_vld;
            r_s7_vld <= r_s6_vld;
        end
        if (en) begin
            r_s6_fsel  <= n_fsel;
            r_s6_asel  <= n_asel;
            r_s6_fden  <= sel4(f_pick, r_s5_ml.mv.dx, r_s5_ml.mv.dy,
                               r_s5_ml.mv.dz, r_s5_ml.mv.de);
            r_s6_aden  <= sel4(a_pick, r_s5_ml.mv.dx, r_s5_ml.mv.dy,
                               r_s5_ml.mv.dz, r_s5_ml.mv.de);
            r_s6_len   <= r_s5_ml.len;
            r_s6_feed  <= r_s5_ml.mv.feed;
            r_s6_accel <= r_s5_ml.mv.accel;

            r_s7_prod[0]       <= ProdW'(r_s6_fsel.lim) * ProdW'(r_s6_len);
            r_s7_prod[1]       <= ProdW'(r_s6_asel.lim) * ProdW'(r_s6_len);
            r_s7_den[0]        <= r_s6_fden;
            r_s7_den[1]        <= r_s6_aden;
            r_s7_fin.feed_sel  <= r_s6_fsel;
            r_s7_fin.accel_sel <= r_s6_asel;
            r_s7_fin.feed      <= r_s6_feed;
            r_s7_fin.accel     <= r_s6_accel;
        end
    end

    // rescale divider: a zero divisor shows up as overflow and saturates
    logic                   db_vld;
    logic [1:0][DataW-1:0]  db_quo;
    logic [1:0]             db_ovf;
    logic [FinW-1:0]        db_side;
    t_fin                   db_fin;

    lfal_div_pipe #(
        .Lanes (2),
        .NumW  (ProdW),
        .DenW  (DataW),
        .QuoW  (DataW),
        .SideW (FinW)
    ) u_div_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s7_vld),
        .i_num   (r_s7_prod),
        .i_den   (r_s7_den),
        .i_side  (r_s7_fin),
        .o_valid (db_vld),
        .o_quo   (db_quo),
        .o_ovf   (db_ovf),
        .o_side  (db_side)
    );

    assign db_fin = t_fin'(db_side);

    logic [DataW-1:0] r_out_feed;
    logic [DataW-1:0] r_out_accel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= db_vld;
        end
        if (en) begin
            priority if (db_fin.feed_sel.keep)    r_out_feed <= db_fin.feed;
            else if (db_fin.feed_sel.use_lim)     r_out_feed <= db_fin.feed_sel.lim;
            else if (db_ovf[0])                   r_out_feed <= '1;
            else                                  r_out_feed <= db_quo[0];

            priority if (db_fin.accel_sel.keep)   r_out_accel <= db_fin.accel;
            else if (db_fin.accel_sel.use_lim)    r_out_accel <= db_fin.accel_sel.lim;
            else if (db_ovf[1])                   r_out_accel <= '1;
            else                                  r_out_accel <= db_quo[1];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_feed  = r_out_feed;
    assign o_out_accel = r_out_accel;

endmodule

@@ rtl/lfal_sqrt_pipe.sv @@
// Pipelined floor square root, one root bit per stage, with sideband data.
module lfal_sqrt_pipe #(
    parameter int RootW = lfal_pkg::DataW,
    parameter int SideW = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [2*RootW-1:0]   i_rad,
    input  logic [SideW-1:0]     i_side,
    output logic                 o_valid,
    output logic [RootW-1:0]     o_root,
    output logic [SideW-1:0]     o_side
);
    import lfal_pkg::*;

    localparam int RemW = RootW + 4;
    localparam int RadW = 2 * RootW;

    logic [RootW-1:0] r_vld;
    logic [RemW-1:0]  r_rem  [RootW];
    logic [RootW-1:0] r_root [RootW];
    logic [RadW-1:0]  r_rad  [RootW];
    logic [SideW-1:0] r_side [RootW];

    logic [RootW-1:0] p_vld;
    logic [RemW-1:0]  p_rem  [RootW];
    logic [RootW-1:0] p_root [RootW];
    logic [RadW-1:0]  p_rad  [RootW];
    logic [SideW-1:0] p_side [RootW];

    logic [RemW-1:0]  n_rem  [RootW];
    logic [RootW-1:0] n_root [RootW];
    logic [RadW-1:0]  n_rad  [RootW];

    always_comb begin
        p_vld[0]  = i_valid;
        p_rem[0]  = '0;
        p_root[0] = '0;
        p_rad[0]  = i_rad;
        p_side[0] = i_side;
        for (int s = 1; s < RootW; s++) begin
            p_vld[s]  = r_vld[s-1];
            p_rem[s]  = r_rem[s-1];
            p_root[s] = r_root[s-1];
            p_rad[s]  = r_rad[s-1];
            p_side[s] = r_side[s-1];
        end
    end

    // bring down two radicand bits, try (root*4 + 1)
    always_comb begin
        logic [RemW-1:0] sh;
        logic [RemW-1:0] trial;
        for (int s = 0; s < RootW; s++) begin
            sh    = {p_rem[s][RemW-3:0], p_rad[s][RadW-1 -: 2]};
            trial = {{(RemW-RootW-2){1'b0}}, p_root[s], 2'b01};
            if (sh >= trial) begin
                n_rem[s]  = sh - trial;
                n_root[s] = {p_root[s][RootW-2:0], 1'b1};
            end else begin
                n_rem[s]  = sh;
                n_root[s] = {p_root[s][RootW-2:0], 1'b0};
            end
            n_rad[s] = {p_rad[s][RadW-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= p_vld;
        end
        if (i_en) begin
            for (int s = 0; s < RootW; s++) begin
                r_rem[s]  <= n_rem[s];
                r_root[s] <= n_root[s];
                r_rad[s]  <= n_rad[s];
                r_side[s] <= p_side[s];
            end
        end
    end

    assign o_valid = r_vld[RootW-1];
    assign o_root  = r_root[RootW-1];
    assign o_side  = r_side[RootW-1];

endmodule

@@ rtl/lfal_div_pipe.sv @@
// Pipelined restoring divider over several lanes, one quotient bit per stage.
module lfal_div_pipe #(
    parameter int Lanes = 2,
    parameter int NumW  = lfal_pkg::ProdW,
    parameter int DenW  = lfal_pkg::DataW,
    parameter int QuoW  = lfal_pkg::DataW,
    parameter int SideW = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [Lanes-1:0][NumW-1:0]  i_num,
    input  logic [Lanes-1:0][DenW-1:0]  i_den,
    input  logic [SideW-1:0]            i_side,
    output logic                        o_valid,
    output logic [Lanes-1:0][QuoW-1:0]  o_quo,
    output logic [Lanes-1:0]            o_ovf,
    output logic [SideW-1:0]            o_side
);
    import lfal_pkg::*;

    localparam int Stages = QuoW + 1;

    logic [Stages-1:0] r_vld;
    logic [DenW-1:0]   r_rem  [Stages][Lanes];
    logic [QuoW-1:0]   r_lq   [Stages][Lanes];   // low numerator bits out, quotient in
    logic [DenW-1:0]   r_den  [Stages][Lanes];
    logic [Lanes-1:0]  r_ovf  [Stages];
    logic [SideW-1:0]  r_side [Stages];

    logic [DenW-1:0]   n_rem  [Stages][Lanes];
    logic [QuoW-1:0]   n_lq   [Stages][Lanes];
    logic [Lanes-1:0]  n_ovf0;

    always_comb begin
        logic [NumW-1:0] hi;
        logic [DenW:0]   t;
        for (int l = 0; l < Lanes; l++) begin
            // first stage: quotient fits only if the upper part is below the divisor
            hi          = i_num[l] >> QuoW;
            n_ovf0[l]   = hi >= NumW'(i_den[l]);
            n_rem[0][l] = hi[DenW-1:0];
            n_lq[0][l]  = i_num[l][QuoW-1:0];
            for (int s = 1; s < Stages; s++) begin
                t = {r_rem[s-1][l], r_lq[s-1][l][QuoW-1]};
                if (t >= {1'b0, r_den[s-1][l]}) begin
                    n_rem[s][l] = DenW'(t - {1'b0, r_den[s-1][l]});
                    n_lq[s][l]  = {r_lq[s-1][l][QuoW-2:0], 1'b1};
                end else begin
                    n_rem[s][l] = t[DenW-1:0];
                    n_lq[s][l]  = {r_lq[s-1][l][QuoW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[Stages-2:0], i_valid};
        end
        if (i_en) begin
            r_ovf[0]  <= n_ovf0;
            r_side[0] <= i_side;
            for (int l = 0; l < Lanes; l++) begin
                r_den[0][l] <= i_den[l];
            end
            for (int s = 1; s < Stages; s++) begin
                r_ovf[s]  <= r_ovf[s-1];
                r_side[s] <= r_side[s-1];
                for (int l = 0; l < Lanes; l++) begin
                    r_den[s][l] <= r_den[s-1][l];
                end
            end
            for (int s = 0; s < Stages; s++) begin
                for (int l = 0; l < Lanes; l++) begin
                    r_rem[s][l] <= n_rem[s][l];
                    r_lq[s][l]  <= n_lq[s][l];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < Lanes; l++) begin
            o_quo[l] = r_lq[Stages-1][l];
        end
    end

    assign o_valid = r_vld[Stages-1];
    assign o_ovf   = r_ovf[Stages-1];
    assign o_side  = r_side[Stages-1];

endmodule
